FILE: hw/rtl/combination_unranker_top_assert.svh
// Assertion macros for the combination unranker checker.
// Expects clk and rst_n in the scope of each use.
`ifndef COMBINATION_UNRANKER_TOP_ASSERT_SVH
`define COMBINATION_UNRANKER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("combination_unranker_top: assertion failed");

// Next-cycle implication, off during reset.
`define CU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("combination_unranker_top: assertion failed");

// Next-cycle implication that also holds across reset.
`define CU_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("combination_unranker_top: assertion failed");

`endif

FILE: hw/rtl/cu_pkg.sv
// Shared types and constants for the combination unranker.
// No dependencies.
package cu_pkg;

  localparam int MAX_ITEMS_DEF = 512;
  localparam int MAX_CARD_DEF  = 4;
  localparam int FIFO_DEPTH    = 2;

  localparam int RANK_W    = 32;
  localparam int POS_W     = 9;
  localparam int SET_W     = 10;
  localparam int SUB_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 4'd1;

  localparam logic [SET_W-1:0] SET_SIZE_RST    = 10'd512;
  localparam logic [SUB_W-1:0] SUBSET_SIZE_RST = 3'd1;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              err;
  } job_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             is_last;
    logic             rank_error;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

endpackage

FILE: hw/rtl/cu_fifo.sv
// Small register FIFO used between the unranker stages.
// Depends on nothing but its parameters.
module cu_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/cu_binom_tbl.sv
// Binomial coefficient table, one row of C(n,0..MAX_CARD) per n.
// Filled by a Pascal sweep after reset; uses cu_pkg.
module cu_binom_tbl #(
  parameter int MAX_ITEMS = 512,
  parameter int MAX_CARD  = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  output logic                                   ready,
  input  logic                                   rd_a_en,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]         rd_a_addr,
  output logic [MAX_CARD:0][cu_pkg::RANK_W-1:0]  rd_a_data,
  input  logic                                   rd_b_en,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]         rd_b_addr,
  output logic [MAX_CARD:0][cu_pkg::RANK_W-1:0]  rd_b_data
);
  import cu_pkg::*;

  localparam int NW = $clog2(MAX_ITEMS + 1);

  typedef logic [MAX_CARD:0][RANK_W-1:0] row_t;

  row_t          mem [0:MAX_ITEMS];
  row_t          row_r, row_nxt;
  logic [NW-1:0] fill_n_r;
  logic          done_r;
  logic [RANK_W:0] sum [1:MAX_CARD];

  assign ready = done_r;

  // Next row from the previous one, saturating at all ones.
  always_comb begin
    row_nxt[0] = RANK_W'(1);
    for (int k = 1; k <= MAX_CARD; k++) begin
      sum[k] = {1'b0, row_r[k-1]} + {1'b0, row_r[k]};
      if (fill_n_r == '0) begin
        row_nxt[k] = '0;
      end else begin
        row_nxt[k] = sum[k][RANK_W] ? '1 : sum[k][RANK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_n_r <= '0;
      done_r   <= 1'b0;
    end else if (!done_r) begin
      if (fill_n_r == NW'(MAX_ITEMS)) begin
        done_r <= 1'b1;
      end else begin
        fill_n_r <= fill_n_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n && !done_r) begin
      row_r         <= row_nxt;
      mem[fill_n_r] <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

FILE: hw/rtl/cu_front.sv
// Front end: accepts ranks and checks them against the combination count.
// Uses cu_pkg and read port A of cu_binom_tbl.
module cu_front #(
  parameter int MAX_ITEMS = 512,
  parameter int MAX_CARD  = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   tbl_ready,
  input  logic [cu_pkg::SET_W-1:0]               set_size,
  input  logic [cu_pkg::SUB_W-1:0]               subset_size,
  input  logic                                   in_push,
  input  logic [cu_pkg::RANK_W-1:0]              in_rank,
  output logic                                   in_full,
  output logic                                   tbl_rd_en,
  output logic [$clog2(MAX_ITEMS+1)-1:0]         tbl_rd_addr,
  input  logic [MAX_CARD:0][cu_pkg::RANK_W-1:0]  tbl_rd_data,
  output logic                                   q_push,
  output cu_pkg::job_t                           q_data,
  input  logic                                   q_full
);
  import cu_pkg::*;

  localparam int NW = $clog2(MAX_ITEMS + 1);
  localparam int CW = (MAX_CARD > 1) ? $clog2(MAX_CARD + 1) : 1;

  logic              hold_valid_r;
  logic [RANK_W-1:0] rank_r;
  logic              accept, size_ok, cfg_bad;
  logic [CW-1:0]     col;
  logic [RANK_W-1:0] count;

  assign in_full = !tbl_ready || (hold_valid_r && q_full);
  assign accept  = in_push && !in_full;

  assign size_ok = (set_size != '0) && (int'(set_size) <= MAX_ITEMS);
  assign cfg_bad = !size_ok || (subset_size == '0) || (int'(subset_size) > MAX_CARD);

  // Row set_size is fetched as the rank is taken in.
  assign tbl_rd_en   = accept;
  assign tbl_rd_addr = size_ok ? NW'(set_size) : '0;

  assign col   = cfg_bad ? '0 : CW'(subset_size);
  assign count = tbl_rd_data[col];

  assign q_push      = hold_valid_r && !q_full;
  assign q_data.rank = rank_r;
  assign q_data.err  = cfg_bad || (rank_r == '0) || (rank_r > count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (q_push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rank_r <= in_rank;
    end
  end

endmodule

FILE: hw/rtl/cu_back.sv
// Back end: walks the bit positions of one checked rank and emits each chosen one.
// Uses cu_pkg and read port B of cu_binom_tbl.
module cu_back #(
  parameter int MAX_ITEMS = 512,
  parameter int MAX_CARD  = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [cu_pkg::SET_W-1:0]               set_size,
  input  logic [cu_pkg::SUB_W-1:0]               subset_size,
  input  logic                                   q_empty,
  input  cu_pkg::job_t                           q_data,
  output logic                                   q_pop,
  output logic                                   tbl_rd_en,
  output logic [$clog2(MAX_ITEMS+1)-1:0]         tbl_rd_addr,
  input  logic [MAX_CARD:0][cu_pkg::RANK_W-1:0]  tbl_rd_data,
  input  logic                                   res_full,
  output logic                                   res_push,
  output cu_pkg::res_t                           res_data
);
  import cu_pkg::*;

  localparam int NW = $clog2(MAX_ITEMS + 1);
  localparam int CW = (MAX_CARD > 1) ? $clog2(MAX_CARD + 1) : 1;

  back_state_t       state_r, state_nxt;
  logic [NW-1:0]     pos_r, pos_nxt;
  logic [RANK_W-1:0] rk_r, rk_nxt;
  logic [SUB_W-1:0]  r_r, r_nxt;
  logic [NW-1:0]     n_w, rem, m;
  logic              zeros_left, place_one;
  logic [RANK_W-1:0] c;

  assign n_w        = NW'(set_size);
  assign rem        = n_w - pos_r;
  assign m          = rem - 1'b1;
  assign zeros_left = int'(rem) > int'(r_r);
  // Table row m is already in the read register; pick column r.
  assign c          = tbl_rd_data[CW'(r_r)];
  assign place_one  = !(zeros_left && (rk_r <= c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    rk_r  <= rk_nxt;
    r_r   <= r_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    rk_nxt      = rk_r;
    r_nxt       = r_r;
    q_pop       = 1'b0;
    res_push    = 1'b0;
    res_data    = '0;
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.err) begin
            if (!res_full) begin
              q_pop               = 1'b1;
              res_push            = 1'b1;
              res_data.is_last    = 1'b1;
              res_data.rank_error = 1'b1;
            end
          end else begin
            q_pop       = 1'b1;
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = n_w - 1'b1;
            pos_nxt     = '0;
            rk_nxt      = q_data.rank;
            r_nxt       = subset_size;
            state_nxt   = BK_WALK;
          end
        end
      end
      BK_WALK: begin
        if (!res_full) begin
          pos_nxt     = pos_r + 1'b1;
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = (m == '0) ? '0 : m - 1'b1;
          if (place_one) begin
            res_push          = 1'b1;
            res_data.position = POS_W'(pos_r);
            res_data.is_last  = (r_r == SUB_W'(1));
            if (zeros_left) begin
              rk_nxt = rk_r - c;
            end
            r_nxt = r_r - 1'b1;
            if (r_r == SUB_W'(1)) begin
              state_nxt = BK_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/combination_unranker_top.sv
// Top level of the combination unranker: configuration registers, front end,
// job queue, binomial table, back end and result queue. Uses cu_pkg.

// Combination unranker. Each rank pushed in is turned into the combination of
// subset_size ones among set_size bit positions that has this 1-based rank in
// lexicographic order (0 before 1); one result is popped per chosen position,
// lowest first, with is_last on the final one. A rank of zero or above
// C(set_size, subset_size), or an out-of-range configuration, gives a single
// result with rank_error and is_last set and position 0. After reset the
// binomial table is built one row per cycle, with in_full high throughout;
// configuration writes are taken meanwhile. In operation the back end walks
// one bit position per cycle while the result queue is not full, reading
// one table row per step; it holds a valid rank until its last one is placed
// and takes no new rank before that. The front end checks the next rank and
// a two-entry queue holds it while the back end is busy; results wait in a
// two-entry output queue.
module combination_unranker_top #(
  parameter int MAX_ITEMS = cu_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CARD  = cu_pkg::MAX_CARD_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cu_pkg::RANK_W-1:0]    in_rank,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [cu_pkg::POS_W-1:0]     out_position,
  output logic                         out_is_last,
  output logic                         out_rank_error,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cu_pkg::CFG_DAT_W-1:0] cfg_data
);
  import cu_pkg::*;

  localparam int NW = $clog2(MAX_ITEMS + 1);

  typedef logic [MAX_CARD:0][RANK_W-1:0] row_t;

  logic [SET_W-1:0] set_size_r;
  logic [SUB_W-1:0] subset_size_r;

  logic          tbl_ready;
  logic          rd_a_en, rd_b_en;
  logic [NW-1:0] rd_a_addr, rd_b_addr;
  row_t          rd_a_data, rd_b_data;

  job_t job_in, job_out;
  logic job_push, job_full, job_pop, job_empty;
  logic [$bits(job_t)-1:0] job_out_bits;

  res_t res_in, res_out;
  logic res_push, res_full;
  logic [$bits(res_t)-1:0] res_out_bits;

  // Configuration: always ready; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r    <= SET_SIZE_RST;
      subset_size_r <= SUBSET_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SET_SIZE:    set_size_r    <= cfg_data[SET_W-1:0];
        CFG_SUBSET_SIZE: subset_size_r <= cfg_data[SUB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Table of C(n,k): port A serves the range check, port B the walk.
  cu_binom_tbl #(
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_CARD (MAX_CARD)
  ) u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .ready    (tbl_ready),
    .rd_a_en  (rd_a_en),
    .rd_a_addr(rd_a_addr),
    .rd_a_data(rd_a_data),
    .rd_b_en  (rd_b_en),
    .rd_b_addr(rd_b_addr),
    .rd_b_data(rd_b_data)
  );

  // Accept and classify each rank.
  cu_front #(
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_CARD (MAX_CARD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .tbl_ready  (tbl_ready),
    .set_size   (set_size_r),
    .subset_size(subset_size_r),
    .in_push    (in_push),
    .in_rank    (in_rank),
    .in_full    (in_full),
    .tbl_rd_en  (rd_a_en),
    .tbl_rd_addr(rd_a_addr),
    .tbl_rd_data(rd_a_data),
    .q_push     (job_push),
    .q_data     (job_in),
    .q_full     (job_full)
  );

  // Hold checked jobs so the front end keeps taking ranks during a walk.
  cu_fifo #(
    .W    ($bits(job_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_data(job_in),
    .full   (job_full),
    .pop    (job_pop),
    .rd_data(job_out_bits),
    .empty  (job_empty)
  );

  assign job_out = job_t'(job_out_bits);

  // Walk positions and emit each chosen one.
  cu_back #(
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_CARD (MAX_CARD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .set_size   (set_size_r),
    .subset_size(subset_size_r),
    .q_empty    (job_empty),
    .q_data     (job_out),
    .q_pop      (job_pop),
    .tbl_rd_en  (rd_b_en),
    .tbl_rd_addr(rd_b_addr),
    .tbl_rd_data(rd_b_data),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_in)
  );

  // Results wait here until popped; the walk stalls while it is full.
  cu_fifo #(
    .W    ($bits(res_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(res_out_bits),
    .empty  (out_empty)
  );

  assign res_out        = res_t'(res_out_bits);
  assign out_position   = res_out.position;
  assign out_is_last    = res_out.is_last;
  assign out_rank_error = res_out.rank_error;

endmodule

FILE: hw/rtl/cu_checker.sv
// Port-level checks for combination_unranker_top, bound to it below.
// Uses the macros in combination_unranker_top_assert.svh.
`include "combination_unranker_top_assert.svh"

module cu_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_full,
  input logic                     out_empty,
  input logic                     out_pop,
  input logic [cu_pkg::POS_W-1:0] out_position,
  input logic                     out_is_last,
  input logic                     out_rank_error
);

  // Reset drains the result queue and restarts the table build.
  `CU_ASSERT_RST(a_rst_empty, !rst_n, out_empty)
  `CU_ASSERT_RST(a_rst_full, !rst_n, in_full)

  // An error result stands alone and carries position 0.
  `CU_ASSERT_IMP(a_err_last, !out_empty && out_rank_error, out_is_last && !(|out_position))

  // A waiting result holds until popped.
  `CU_ASSERT_NXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable({out_position, out_is_last, out_rank_error}))

endmodule

bind combination_unranker_top cu_checker u_cu_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for combination_unranker_top: ranks go in through the
// push/full port, the chosen positions are predicted and checked on every pop.
// Depends on cu_pkg and the combination_unranker_top RTL.
module tb_top;
  import cu_pkg::*;

  localparam int SET_MAX          = MAX_ITEMS_DEF;
  localparam int CARD_MAX         = MAX_CARD_DEF;
  // A valid rank keeps the back end busy until its last one is placed.
  localparam int END_DRAIN_CYCLES = 600;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_PICKS = 40;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_push        = 1'b0;
  logic                 in_full;
  logic [RANK_W-1:0]    in_rank        = '0;
  logic                 out_empty;
  logic                 out_pop        = 1'b0;
  logic [POS_W-1:0]     out_position;
  logic                 out_is_last;
  logic                 out_rank_error;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_DAT_W-1:0] cfg_data       = '0;

  // Saturated binomial table C(n,k), rebuilt here from Pascal's rule.
  logic [31:0]       binom_sat [0:SET_MAX][0:CARD_MAX];
  // Register values as the block holds them.
  logic [SET_W-1:0]  set_shadow    = SET_SIZE_RST;
  logic [SUB_W-1:0]  subset_shadow = SUBSET_SIZE_RST;

  logic [RANK_W-1:0] pending_ranks[$];
  res_t              expected_picks[$];

  int send_gap      = 0;
  int pop_gap       = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  bit quiet_tail    = 1'b0;
  int picks_checked = 0;
  int error_count   = 0;

  always #5 clk = ~clk;

  combination_unranker_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rank        (in_rank),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_position   (out_position),
    .out_is_last    (out_is_last),
    .out_rank_error (out_rank_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin : build_binomials
    logic [63:0] sum;
    for (int n = 0; n <= SET_MAX; n++) begin
      for (int k = 0; k <= CARD_MAX; k++) begin
        if (k == 0) begin
          binom_sat[n][k] = 32'd1;
        end else if (n == 0) begin
          binom_sat[n][k] = 32'd0;
        end else begin
          sum = {32'd0, binom_sat[n-1][k-1]} + {32'd0, binom_sat[n-1][k]};
          // Clamp at the 32-bit ceiling so compares against a rank stay exact.
          binom_sat[n][k] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
    end
  end

  // Number of combinations under the current settings; zero when the
  // settings are out of range, which turns every rank into an error.
  function automatic logic [31:0] combo_count();
    if (set_shadow == 0 || set_shadow > SET_MAX ||
        subset_shadow == 0 || subset_shadow > CARD_MAX)
      return 32'd0;
    return binom_sat[set_shadow][subset_shadow];
  endfunction

  // Walk the bit positions from first to last and queue one expected pick per
  // placed one; an out-of-range rank queues the single error result instead.
  function automatic void predict_combination(logic [RANK_W-1:0] rank_in);
    logic [31:0] left;
    logic [31:0] c;
    int          n;
    int          r;
    int          m;
    bit          zeros_left;
    res_t        pick;
    n    = set_shadow;
    r    = subset_shadow;
    left = rank_in;
    if (rank_in == 0 || rank_in > combo_count()) begin
      pick.position   = '0;
      pick.is_last    = 1'b1;
      pick.rank_error = 1'b1;
      expected_picks.push_back(pick);
      return;
    end
    for (int pos = 0; pos < n && r > 0; pos++) begin
      m          = n - 1 - pos;
      zeros_left = (n - pos) > r;
      c          = binom_sat[m][r];
      // Place a zero while the rank still fits among the strings that do so.
      if (zeros_left && left <= c)
        continue;
      if (zeros_left)
        left -= c;
      r--;
      pick.position   = pos[POS_W-1:0];
      pick.is_last    = (r == 0);
      pick.rank_error = 1'b0;
      expected_picks.push_back(pick);
    end
  endfunction

  function automatic void report_error(string msg);
    if (error_count < 10)
      $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endfunction

  // Rank driver: offer the oldest pending rank, hold it while the block is
  // full, predict its picks on acceptance, and insert random send gaps.
  always @(posedge clk) begin : rank_driver
    if (!rst_n) begin
      in_push  <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_push && !in_full) begin
        predict_combination(in_rank);
        void'(pending_ranks.pop_front());
      end
      if (in_push && in_full) begin
        // Hold the offered rank until the block takes it.
      end else if (send_gap > 0) begin
        in_push  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_ranks.size() != 0) begin
        in_push <= 1'b1;
        in_rank <= pending_ranks[0];
        if (!quiet_tail && $urandom_range(7) == 0)
          send_gap <= $urandom_range(19, 1);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Result monitor: check each popped transaction against the oldest
  // expectation, then decide whether to pop on the next edge. Once, early in
  // the run, stop popping for a long stretch so the block backs up into in_full.
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst_n) begin
      out_pop   <= 1'b0;
      pop_gap   <= 0;
      hold_left <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_picks.size() == 0) begin
          report_error($sformatf("unexpected result: position %0d last %0b error %0b",
                                 out_position, out_is_last, out_rank_error));
        end else begin
          want = expected_picks.pop_front();
          if (out_position !== want.position || out_is_last !== want.is_last ||
              out_rank_error !== want.rank_error)
            report_error($sformatf(
              "result %0d: expected position %0d last %0b error %0b, got %0d %0b %0b",
              picks_checked, want.position, want.is_last, want.rank_error,
              out_position, out_is_last, out_rank_error));
        end
        picks_checked <= picks_checked + 1;
      end
      if (hold_left > 0) begin
        out_pop   <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && picks_checked >= HOLD_AFTER_PICKS) begin
        out_pop   <= 1'b0;
        hold_left <= LONG_HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else begin
        out_pop <= 1'b1;
        if (!quiet_tail && $urandom_range(9) == 0)
          pop_gap <= $urandom_range(19, 1);
      end
    end
  end

  // Wait until every rank is taken and every expected pick has been popped.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ranks.size() != 0 || expected_picks.size() != 0 || in_push);
  endtask

  // One register write transaction; the shadow copy follows at the handshake.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_SET_SIZE)
      set_shadow = val;
    else if (idx == CFG_SUBSET_SIZE)
      subset_shadow = val[SUB_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // Drain the block, then move to new settings.
  task automatic set_mode(int set_val, int sub_val);
    wait_drained();
    write_reg(CFG_SET_SIZE, set_val[CFG_DAT_W-1:0]);
    write_reg(CFG_SUBSET_SIZE, sub_val[CFG_DAT_W-1:0]);
    @(negedge clk);
  endtask

  // Mostly in-range ranks with random content; the rest are zero, one past the
  // count, or any 32-bit value.
  task automatic queue_random(int count);
    logic [31:0] total;
    logic [31:0] r;
    total = combo_count();
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: r = $urandom();
        1: r = (total == 0 || $urandom_range(1) == 0) ? 32'd0 : total + 32'd1;
        default: r = (total == 0) ? $urandom() : $urandom_range(total, 1);
      endcase
      pending_ranks.push_back(r);
    end
  endtask

  initial begin : stimulus
    logic [31:0] total;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, one of 512: first, last, one past the end, zero, all ones.
    pending_ranks.push_back(32'd1);
    pending_ranks.push_back(32'd512);
    pending_ranks.push_back(32'd513);
    pending_ranks.push_back(32'd0);
    pending_ranks.push_back(32'hFFFF_FFFF);
    queue_random(30);

    // Two of four: every rank in order, then one past the end.
    set_mode(4, 2);
    for (int r = 1; r <= 7; r++)
      pending_ranks.push_back(r);
    queue_random(60);

    // Smallest set.
    set_mode(1, 1);
    pending_ranks.push_back(32'd1);
    pending_ranks.push_back(32'd2);
    queue_random(15);

    // Every position chosen.
    set_mode(4, 4);
    pending_ranks.push_back(32'd1);
    pending_ranks.push_back(32'd2);
    queue_random(5);

    // Subset larger than the set: nothing is valid.
    set_mode(3, 4);
    pending_ranks.push_back(32'd1);
    queue_random(4);

    set_mode(16, 3);
    queue_random(80);

    // Largest settings: each rank walks up to the full set, so keep it short.
    set_mode(SET_MAX, CARD_MAX);
    total = combo_count();
    pending_ranks.push_back(32'd1);
    pending_ranks.push_back(total);
    pending_ranks.push_back(total + 32'd1);
    pending_ranks.push_back(32'hFFFF_FFFF);
    queue_random(20);

    // Out-of-range settings give the error result for any rank.
    set_mode(0, 2);
    queue_random(3);
    set_mode(SET_MAX + 1, 1);
    queue_random(3);
    set_mode(1023, 7);
    queue_random(3);
    set_mode(10, 0);
    queue_random(3);
    set_mode(10, CARD_MAX + 1);
    queue_random(3);

    set_mode(64, 3);
    queue_random(120);

    // Final stretch without any idling on either side.
    set_mode(20, 2);
    quiet_tail = 1'b1;
    queue_random(100);

    wait_drained();
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    if (expected_picks.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_picks.size()));
    if (error_count == 0)
      $display("combination_unranker_top regression: pass");
    else
      $display("combination_unranker_top regression: fail");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("combination_unranker_top regression: fail");
    $finish;
  end

endmodule
